>>> design/lmts_pkg.sv
// Types and constants shared by the LCD mode timing sequencer modules.
package lmts_pkg;

   localparam int ACC_W      = 10;
   localparam int LINE_W     = 8;
   localparam int CYC_W      = 8;
   localparam int STAT_EN_W  = 4;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 16;

   localparam logic [ACC_W-1:0] ACC_MAX = '1;

   // stat_enables bit positions
   localparam int STAT_EN_HBLANK = 0;
   localparam int STAT_EN_VBLANK = 1;
   localparam int STAT_EN_OAM    = 2;
   localparam int STAT_EN_LYC    = 3;

   typedef enum logic [1:0] {
      MODE_HOR_BLANK = 2'd0,
      MODE_VER_BLANK = 2'd1,
      MODE_OBJ_SCAN  = 2'd2,
      MODE_DRAW      = 2'd3
   } mode_type;

   typedef struct packed {
      logic [CYC_W-1:0]     cycles;
      logic                 lcd_enable;
      logic [STAT_EN_W-1:0] stat_enables;
      logic [LINE_W-1:0]    line_compare;
   } tick_type;

   typedef struct packed {
      mode_type           mode;
      logic [LINE_W-1:0]  line;
      logic [ACC_W-1:0]   acc;
      logic               coincidence;
   } seq_state_type;

   typedef struct packed {
      logic vblank_irq;
      logic stat_irq;
      logic render_line;
      logic frame_done;
   } pulse_type;

endpackage

>>> design/lmts_step.sv
// Next-state and pulse logic for one tick of the mode timing sequencer.
module lmts_step import lmts_pkg::*; #(
   parameter int OAM_CYCLES    = 80,
   parameter int DRAW_CYCLES   = 172,
   parameter int LINE_CYCLES   = 456,
   parameter int VISIBLE_LINES = 144,
   parameter int TOTAL_LINES   = 154
) (
   input  seq_state_type state_cur,
   input  tick_type      tick,
   output seq_state_type state_nxt,
   output pulse_type     pulses
);

   localparam logic [ACC_W-1:0]  OAM_END   = ACC_W'(OAM_CYCLES);
   localparam logic [ACC_W-1:0]  DRAW_END  = ACC_W'(OAM_CYCLES + DRAW_CYCLES);
   localparam logic [ACC_W-1:0]  LINE_END  = ACC_W'(LINE_CYCLES);
   localparam logic [LINE_W-1:0] VIS_LAST  = LINE_W'(VISIBLE_LINES);
   localparam logic [LINE_W-1:0] TOT_LAST  = LINE_W'(TOTAL_LINES);

   logic [ACC_W:0]    sum;
   logic [ACC_W-1:0]  acc_sat;
   logic [ACC_W-1:0]  acc_wrap;
   logic              line_end;
   logic [LINE_W-1:0] line_inc;
   logic              enter_vblank;
   logic              frame_wrap;
   logic [LINE_W-1:0] vb_line;
   logic              lyc_hb;
   logic              lyc_vb;

   assign sum          = {1'b0, state_cur.acc} + (ACC_W+1)'(tick.cycles);
   assign acc_sat      = sum[ACC_W] ? ACC_MAX : sum[ACC_W-1:0];
   assign acc_wrap     = acc_sat - LINE_END;
   assign line_end     = acc_sat >= LINE_END;
   assign line_inc     = state_cur.line + LINE_W'(1);
   assign enter_vblank = line_inc >= VIS_LAST;
   assign frame_wrap   = line_inc >= TOT_LAST;
   assign vb_line      = frame_wrap ? '0 : line_inc;
   assign lyc_hb       = line_inc == tick.line_compare;
   assign lyc_vb       = vb_line == tick.line_compare;

   // next state
   always_comb begin
      state_nxt = state_cur;
      if (tick.lcd_enable) begin
         state_nxt.acc = acc_sat;
         unique case (state_cur.mode)
            MODE_OBJ_SCAN: begin
               if (acc_sat >= OAM_END) state_nxt.mode = MODE_DRAW;
            end
            MODE_DRAW: begin
               if (acc_sat >= DRAW_END) state_nxt.mode = MODE_HOR_BLANK;
            end
            MODE_HOR_BLANK: begin
               if (line_end) begin
                  state_nxt.acc         = acc_wrap;
                  state_nxt.line        = line_inc;
                  state_nxt.mode        = enter_vblank ? MODE_VER_BLANK : MODE_OBJ_SCAN;
                  state_nxt.coincidence = lyc_hb;
               end
            end
            MODE_VER_BLANK: begin
               if (line_end) begin
                  state_nxt.acc         = acc_wrap;
                  state_nxt.line        = vb_line;
                  if (frame_wrap) state_nxt.mode = MODE_OBJ_SCAN;
                  state_nxt.coincidence = lyc_vb;
               end
            end
            default: state_nxt = state_cur;
         endcase
      end
   end

   // pulses
   always_comb begin
      pulses = '0;
      if (tick.lcd_enable) begin
         unique case (state_cur.mode)
            MODE_OBJ_SCAN: begin
               pulses = '0;
            end
            MODE_DRAW: begin
               if (acc_sat >= DRAW_END) begin
                  pulses.render_line = 1'b1;
                  pulses.stat_irq    = tick.stat_enables[STAT_EN_HBLANK];
               end
            end
            MODE_HOR_BLANK: begin
               if (line_end) begin
                  pulses.vblank_irq = enter_vblank;
                  pulses.frame_done = enter_vblank;
                  pulses.stat_irq   = (enter_vblank ? tick.stat_enables[STAT_EN_VBLANK]
                                                    : tick.stat_enables[STAT_EN_OAM])
                                    | (lyc_hb & tick.stat_enables[STAT_EN_LYC]);
               end
            end
            MODE_VER_BLANK: begin
               if (line_end) begin
                  pulses.stat_irq = (frame_wrap & tick.stat_enables[STAT_EN_OAM])
                                  | (lyc_vb & tick.stat_enables[STAT_EN_LYC]);
               end
            end
            default: pulses = '0;
         endcase
      end
   end

endmodule

>>> design/lcd_mode_timing_sequencer_top.sv
// Top level of the LCD mode timing sequencer: input register, step logic, result register.
//
//   channel | ports                          | word
//   --------+--------------------------------+----------------------------------------
//   req     | req_tvalid/req_tready/req_tdata | one tick: cycles, enable, enables, cmp
//   rsp     | rsp_tvalid/rsp_tready/rsp_tdata | mode, line, coincidence and pulses
//
// One tick per clock while rsp_tready stays high; an accepted tick passes through the
// input register, then the mode/line update into the result register, before
// rsp_tvalid rises.
// Synchronous active-high reset: mode oam, line 0, accumulator 0, flag 0.
// The timing state advances only when a tick moves into the result register,
// so a stall on rsp holds the state and backs up req without loss.
module lcd_mode_timing_sequencer_top import lmts_pkg::*; #(
   parameter int OAM_CYCLES    = 80,
   parameter int DRAW_CYCLES   = 172,
   parameter int LINE_CYCLES   = 456,
   parameter int VISIBLE_LINES = 144,
   parameter int TOTAL_LINES   = 154
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [7:0] cycles, [8] lcd_enable, [12:9] stat_enables, [20:13] line_compare
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [1:0] mode, [9:2] line, [10] coincidence, [11] vblank_irq, [12] stat_irq,
   // [13] render_line, [14] frame_done
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic          in_valid_ff, in_valid_in;
   tick_type      in_tick_ff, in_tick_in;
   logic          out_valid_ff, out_valid_in;
   logic [RSP_DATA_W-1:0] out_data_ff, out_data_in;
   seq_state_type state_ff, state_in;
   seq_state_type state_nxt;
   pulse_type     pulses;
   logic          advance;
   logic          req_take;

   // tick moves to the result register when the result slot is free or draining
   assign advance    = in_valid_ff & (~out_valid_ff | rsp_tready);
   assign req_tready = ~in_valid_ff | advance;
   assign req_take   = req_tvalid & req_tready;

   always_comb begin
      in_tick_in.cycles       = req_tdata[7:0];
      in_tick_in.lcd_enable   = req_tdata[8];
      in_tick_in.stat_enables = req_tdata[12:9];
      in_tick_in.line_compare = req_tdata[20:13];
   end

   lmts_step #(
      .OAM_CYCLES    (OAM_CYCLES),
      .DRAW_CYCLES   (DRAW_CYCLES),
      .LINE_CYCLES   (LINE_CYCLES),
      .VISIBLE_LINES (VISIBLE_LINES),
      .TOTAL_LINES   (TOTAL_LINES)
   ) u_step (
      .state_cur (state_ff),
      .tick      (in_tick_ff),
      .state_nxt (state_nxt),
      .pulses    (pulses)
   );

   always_comb begin
      in_valid_in  = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      out_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);
      state_in     = advance ? state_nxt : state_ff;
      out_data_in  = {1'b0, pulses.frame_done, pulses.render_line, pulses.stat_irq,
                      pulses.vblank_irq, state_nxt.coincidence, state_nxt.line,
                      state_nxt.mode};
   end

   // control and timing state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff           <= 1'b0;
         out_valid_ff          <= 1'b0;
         state_ff.mode         <= MODE_OBJ_SCAN;
         state_ff.line         <= '0;
         state_ff.acc          <= '0;
         state_ff.coincidence  <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_tick_ff <= in_tick_in;
      end
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the LCD mode timing sequencer: stimulus, prediction, checks.
`timescale 1ns / 100ps

module tb_top;
   import lmts_pkg::*;

   // Timing set used for both the DUT and the predictor (the DUT defaults)
   localparam int OAM_CYCLES    = 80;
   localparam int DRAW_CYCLES   = 172;
   localparam int LINE_CYCLES   = 456;
   localparam int VISIBLE_LINES = 144;
   localparam int TOTAL_LINES   = 154;

   localparam int RESET_CYCLES    = 6;
   localparam int RANDOM_ENABLED  = 2000;  // enabled ticks in the random part
   localparam int DRAIN_AT        = 1000;  // index of the random word before which the sender drains
   localparam int HOLDOFF_START   = 600;   // receiver cycle where the long stall starts
   localparam int HOLDOFF_LEN     = 200;
   localparam int SETTLE_CYCLES   = 8;     // idle cycles after the last result before the summary
   localparam int CYCLE_LIMIT     = 200000;

   // What one result word carries
   typedef struct packed {
      mode_type          mode;
      logic [LINE_W-1:0] line;
      logic              coincidence;
      pulse_type         pulses;
   } lcd_status_type;

   typedef struct {
      tick_type tick;
      bit       hold_for_drain;  // wait until all results are back before sending
   } queued_tick_type;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // [7:0] cycles, [8] lcd_enable, [12:9] stat_enables, [20:13] line_compare, [23:21] zero
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // [1:0] mode, [9:2] line, [10] coincidence, [11] vblank_irq, [12] stat_irq,
   // [13] render_line, [14] frame_done, [15] zero
   logic [RSP_DATA_W-1:0] rsp_tdata;

   queued_tick_type pending_ticks[$];   // words not yet offered
   lcd_status_type  pending_status[$];  // predicted results, oldest first
   seq_state_type   model_state;        // predictor copy, advanced on accepted words
   seq_state_type   stim_state;         // generator copy, used to aim line_compare

   logic req_took = 1'b0;             // req word accepted at the last rising edge
   int   error_count    = 0;
   int   results_seen   = 0;
   int   frames_seen    = 0;
   int   stat_irqs_seen = 0;
   int   lyc_hits_seen  = 0;
   int   wraps_seen     = 0;
   int   burst_left     = 1;
   int   gap_left       = 0;
   int   rx_cycle       = 0;
   int   holdoff_left   = 0;
   int   stall_pct      = 0;
   int   cycle_count    = 0;

   lcd_mode_timing_sequencer_top #(
      .OAM_CYCLES    (OAM_CYCLES),
      .DRAW_CYCLES   (DRAW_CYCLES),
      .LINE_CYCLES   (LINE_CYCLES),
      .VISIBLE_LINES (VISIBLE_LINES),
      .TOTAL_LINES   (TOTAL_LINES)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------
   function automatic seq_state_type power_on_state();
      seq_state_type st;
      st.mode        = MODE_OBJ_SCAN;
      st.line        = '0;
      st.acc         = '0;
      st.coincidence = 1'b0;
      return st;
   endfunction

   // One tick: accumulate dots, at most one mode/line step, one-tick pulses.
   function automatic void advance_timing(inout seq_state_type st, input tick_type tk,
                                          output lcd_status_type res);
      logic [ACC_W:0] sum;
      pulse_type      p;
      p = '0;
      if (tk.lcd_enable) begin
         sum    = st.acc + tk.cycles;
         st.acc = (sum > ACC_MAX) ? ACC_MAX : sum[ACC_W-1:0];  // saturate
         case (st.mode)
            MODE_OBJ_SCAN: begin
               if (st.acc >= OAM_CYCLES) st.mode = MODE_DRAW;
            end
            MODE_DRAW: begin
               if (st.acc >= OAM_CYCLES + DRAW_CYCLES) begin
                  p.render_line = 1'b1;
                  st.mode       = MODE_HOR_BLANK;
                  if (tk.stat_enables[STAT_EN_HBLANK]) p.stat_irq = 1'b1;
               end
            end
            default: begin
               // hblank and vblank both close a line here
               if (st.acc >= LINE_CYCLES) begin
                  st.acc  = st.acc - LINE_CYCLES;
                  st.line = st.line + 1'b1;  // wraps mod 256
                  if (st.mode == MODE_HOR_BLANK) begin
                     if (st.line >= VISIBLE_LINES) begin
                        st.mode      = MODE_VER_BLANK;
                        p.vblank_irq = 1'b1;
                        p.frame_done = 1'b1;
                        if (tk.stat_enables[STAT_EN_VBLANK]) p.stat_irq = 1'b1;
                     end else begin
                        st.mode = MODE_OBJ_SCAN;
                        if (tk.stat_enables[STAT_EN_OAM]) p.stat_irq = 1'b1;
                     end
                  end else if (st.line >= TOTAL_LINES) begin
                     st.line = '0;
                     st.mode = MODE_OBJ_SCAN;
                     if (tk.stat_enables[STAT_EN_OAM]) p.stat_irq = 1'b1;
                  end
                  st.coincidence = (st.line == tk.line_compare);
                  if (st.coincidence && tk.stat_enables[STAT_EN_LYC]) p.stat_irq = 1'b1;
               end
            end
         endcase
      end
      res.mode        = st.mode;
      res.line        = st.line;
      res.coincidence = st.coincidence;
      res.pulses      = p;
   endfunction

   // Queue a tick and step the generator copy so later compares can be aimed.
   task automatic queue_tick(input int cyc, input bit on, input int enables, input int cmp,
                             input bit hold);
      queued_tick_type q;
      lcd_status_type  unused;
      q.tick.cycles       = cyc[CYC_W-1:0];
      q.tick.lcd_enable   = on;
      q.tick.stat_enables = enables[STAT_EN_W-1:0];
      q.tick.line_compare = cmp[LINE_W-1:0];
      q.hold_for_drain    = hold;
      advance_timing(stim_state, q.tick, unused);
      pending_ticks.push_back(q);
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         error_count++;
      end
   endtask

   // ------------------------------------------------------------------
   // Sender: bursts of random length, random gaps, optional drain pause.
   // Next values are worked out first so each signal gets one update per edge.
   // ------------------------------------------------------------------
   always @(negedge clock) begin : drive_req
      logic                  next_valid;
      logic [REQ_DATA_W-1:0] next_data;
      queued_tick_type       head;
      next_valid = req_tvalid;
      next_data  = req_tdata;
      if (reset) begin
         next_valid = 1'b0;
      end else if (!req_tvalid || req_took) begin
         next_valid = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
         end else if (pending_ticks.size() != 0 &&
                      !(pending_ticks[0].hold_for_drain && pending_status.size() != 0)) begin
            head       = pending_ticks.pop_front();
            next_valid = 1'b1;
            next_data  = {3'b000, head.tick.line_compare, head.tick.stat_enables,
                          head.tick.lcd_enable, head.tick.cycles};
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 40);
               gap_left   = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 6);
            end
         end
      end
      req_tvalid <= next_valid;
      req_tdata  <= next_data;
   end

   // ------------------------------------------------------------------
   // Receiver: random stall level (none, light, heavy),
   // plus one long hold-off so the pipe fills and req_tready drops.
   // ------------------------------------------------------------------
   always @(negedge clock) begin : drive_rsp
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rx_cycle++;
         if (rx_cycle == HOLDOFF_START) holdoff_left = HOLDOFF_LEN;
         if (rx_cycle % 48 == 0) begin
            case ($urandom_range(0, 2))
               0:       stall_pct = 0;
               1:       stall_pct = 30;
               default: stall_pct = 75;
            endcase
         end
         if (holdoff_left > 0) begin
            holdoff_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   // ------------------------------------------------------------------
   // Monitor: predict on each accepted req word, check each rsp word.
   // ------------------------------------------------------------------
   always @(posedge clock) begin : watch_ports
      tick_type          tk;
      lcd_status_type    want;
      lcd_status_type    got;
      logic [LINE_W-1:0] prev_line;
      if (reset) begin
         model_state = power_on_state();
         req_took   <= 1'b0;
      end else begin
         req_took <= req_tvalid && req_tready;
         if (rsp_tvalid && rsp_tready) begin
            got.mode               = mode_type'(rsp_tdata[1:0]);
            got.line               = rsp_tdata[9:2];
            got.coincidence        = rsp_tdata[10];
            got.pulses.vblank_irq  = rsp_tdata[11];
            got.pulses.stat_irq    = rsp_tdata[12];
            got.pulses.render_line = rsp_tdata[13];
            got.pulses.frame_done  = rsp_tdata[14];
            if (pending_status.size() == 0) begin
               $display("%0t: unexpected result word, expected none, actual %h",
                        $time, rsp_tdata);
               error_count++;
            end else begin
               want = pending_status.pop_front();
               check_field("mode", want.mode, got.mode);
               check_field("line", want.line, got.line);
               check_field("coincidence", want.coincidence, got.coincidence);
               check_field("vblank_irq", want.pulses.vblank_irq, got.pulses.vblank_irq);
               check_field("stat_irq", want.pulses.stat_irq, got.pulses.stat_irq);
               check_field("render_line", want.pulses.render_line, got.pulses.render_line);
               check_field("frame_done", want.pulses.frame_done, got.pulses.frame_done);
               results_seen++;
               if (want.pulses.frame_done) frames_seen++;
               if (want.pulses.stat_irq) stat_irqs_seen++;
            end
         end
         if (req_tvalid && req_tready) begin
            tk.cycles       = req_tdata[7:0];
            tk.lcd_enable   = req_tdata[8];
            tk.stat_enables = req_tdata[12:9];
            tk.line_compare = req_tdata[20:13];
            prev_line       = model_state.line;
            advance_timing(model_state, tk, want);
            // line steps that hit the compare value, and frame wraps
            if (want.line != prev_line) begin
               if (want.coincidence) lyc_hits_seen++;
               if (want.line == '0) wraps_seen++;
            end
            pending_status.push_back(want);
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles, %0d results outstanding",
                  $time, CYCLE_LIMIT, pending_status.size());
         $display("lcd_mode_timing_sequencer_top regression: fail");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus and end of run
   // ------------------------------------------------------------------
   initial begin : run_test
      int enabled_ticks;
      int random_count;
      int cyc;
      int cmp;
      int sel;
      bit on;
      enabled_ticks = 0;
      random_count  = 0;
      stim_state    = power_on_state();

      // Directed: frozen display, no-change tick, each in-line mode boundary hit exactly,
      // render/hblank, line advance with coincidence, field extremes.
      queue_tick(255, 1'b0, 15, 255, 1'b0);  // disabled, other fields all high
      queue_tick(  0, 1'b0,  0,   0, 1'b0);  // disabled, all fields low
      queue_tick(  0, 1'b1,  0,   0, 1'b0);  // enabled, nothing elapses
      queue_tick( 79, 1'b1, 15,   0, 1'b0);  // one short of end of oam
      queue_tick(  1, 1'b1, 15,   0, 1'b0);  // oam -> drawing exactly at 80
      queue_tick(171, 1'b1, 15,   1, 1'b0);  // one short of end of drawing
      queue_tick(  1, 1'b1, 15,   1, 1'b0);  // drawing -> hblank, render, hblank irq
      queue_tick(203, 1'b1, 15,   1, 1'b0);  // one short of end of line
      queue_tick(255, 1'b0, 15,   1, 1'b0);  // disabled mid-hblank
      queue_tick(  1, 1'b1, 15,   1, 1'b0);  // line 1, oam irq, compare hit
      queue_tick(255, 1'b1,  0,   7, 1'b0);  // max dots, straight to drawing
      queue_tick(255, 1'b1,  0,   7, 1'b0);  // hblank with irq disabled
      queue_tick(255, 1'b1, 15,   3, 1'b0);  // line 2 with carry-over, compare miss
      queue_tick(  0, 1'b1, 15,   2, 1'b0);  // carried dots move oam -> drawing
      queue_tick(  0, 1'b1,  1,   2, 1'b0);  // and drawing -> hblank
      queue_tick(  0, 1'b1, 15,   2, 1'b0);  // no change
      queue_tick(255, 1'b0, 10, 170, 1'b1);  // sender drains before this one

      // Random: mostly enabled ticks with large dot counts so whole frames
      // pass; compare aimed at the next line half of the time.
      while (enabled_ticks < RANDOM_ENABLED) begin
         on  = ($urandom_range(0, 99) >= 12);
         sel = $urandom_range(0, 9);
         if (sel == 0)     cyc = $urandom_range(0, 1) ? 255 : 0;
         else if (sel < 3) cyc = $urandom_range(200, 255);
         else              cyc = $urandom_range(0, 255);
         sel = $urandom_range(0, 99);
         if (sel < 50)      cmp = (stim_state.line + 1) % TOTAL_LINES;
         else if (sel < 65) cmp = stim_state.line;
         else if (sel < 90) cmp = $urandom_range(0, TOTAL_LINES - 1);
         else               cmp = $urandom_range(0, 255);
         queue_tick(cyc, on, $urandom_range(0, 15), cmp, random_count == DRAIN_AT);
         random_count++;
         if (on) enabled_ticks++;
      end

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_ticks.size() != 0 || req_tvalid) @(posedge clock);
      while (pending_status.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("covered %0d result words: %0d frames, %0d wraps, %0d stat irqs, %0d compare hits",
               results_seen, frames_seen, wraps_seen, stat_irqs_seen, lyc_hits_seen);
      $display("with bursty input, random output stalls, one long hold-off and a drain pause");
      if (error_count == 0) begin
         $display("lcd_mode_timing_sequencer_top regression: pass");
      end else begin
         $display("lcd_mode_timing_sequencer_top regression: fail");
      end
      $finish;
   end

endmodule

>>> sim.f
design/lmts_pkg.sv
design/lmts_step.sv
design/lcd_mode_timing_sequencer_top.sv
tb/tb_top.sv
